// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset, with a fixed message
`define ILIST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("list assertion failed");

// Check a property on every rising edge outside reset, with a given message
`define ILIST_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// ----- sv/ilist_pkg.sv -----
// ----------------------------------------------------------------------------
// ilist_pkg
// Command codes, default capacity and the control bundle for the list cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ilist_pkg;

  // Default number of list entries
  localparam int unsigned IlistCapacity = 32;

  // Width of the command field
  localparam int unsigned CmdW = 2;

  // Command codes
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd2;

  // Per-request control broadcast to every cell
  typedef struct packed {
    logic ins;   // insert accepted and legal
    logic ers;   // erase accepted and legal
    logic srch;  // search accepted
  } ilist_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/ilist_cell.sv -----
// ----------------------------------------------------------------------------
// ilist_cell
// One list entry: shifts up on insert, down on erase, compares on search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilist_cell import ilist_pkg::*; #(
  parameter int unsigned CNT_W = 6,
  parameter int unsigned INDEX = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ilist_ctrl_t         ctrl_i,
  input  wire logic [CNT_W-1:0]    pos_i,
  input  wire logic [CNT_W-1:0]    count_i,
  input  wire logic signed [31:0]  value_i,
  input  wire logic signed [31:0]  left_i,
  input  wire logic signed [31:0]  right_i,
  output logic signed [31:0]       entry_o,
  output logic                     match_o
);

  localparam logic [CNT_W-1:0] Idx = CNT_W'(INDEX);

  logic signed [31:0] entry_q, entry_d;
  logic               match_q, match_d;
  logic               at_or_above;

  assign at_or_above = (Idx >= pos_i);

  // Pick the new entry from value, lower neighbour or upper neighbour
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && at_or_above) begin
      entry_d = (Idx == pos_i) ? value_i : left_i;
    end else if (ctrl_i.ers && at_or_above) begin
      entry_d = right_i;
    end
  end

  // Compare only live entries
  assign match_d = ctrl_i.srch && (Idx < count_i) && (entry_q == value_i);

  // Hold the entry; no reset, contents are undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Register the compare result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ----- sv/indexed_list_insert_erase_search.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_search
// Ordered list of signed 32-bit values with insert, erase and search.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start_i high and busy_o low; busy_o
// is high only in the first cycle after reset, so one request can be issued
// every cycle. Each request gives exactly one result, shown for one cycle with
// done_o high in the cycle right after the request. The list lives in a row of
// CAPACITY cells, each holding one entry and shifting to its neighbour, so
// insert and erase take effect at the edge that accepts them; search compares
// all cells at that same edge and ORs the registered matches in the result
// cycle. The receiver cannot stall, so results must be taken as shown.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_erase_search import ilist_pkg::*; #(
  parameter int unsigned CAPACITY = IlistCapacity,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [CmdW-1:0]     cmd_i,
  input  wire logic [CNT_W-1:0]    position_i,
  input  wire logic signed [31:0]  item_value_i,
  output logic                     done_o,
  output logic                     ok_o,
  output logic [CNT_W-1:0]         count_now_o
);

  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

  logic               busy_q;
  logic               accept;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               done_q;
  logic               ok_q, ok_d;
  logic               srch_q;
  ilist_ctrl_t        ctrl;
  logic signed [31:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0] match_w;

  assign accept = start_i && !busy_q;

  // Decode the request and check its position against the count
  always_comb begin
    ctrl.ins  = accept && (cmd_i == CMD_INSERT) && (position_i <= count_q)
                && (count_q != CapC);
    ctrl.ers  = accept && (cmd_i == CMD_ERASE) && (position_i < count_q);
    ctrl.srch = accept && (cmd_i == CMD_SEARCH);
    ok_d      = ctrl.ins || ctrl.ers;
    count_d   = count_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.ers) begin
      count_d = count_q - 1'b1;
    end
  end

  // Row of cells, each wired to its neighbours; an end cell takes its own entry in place of the missing one
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = entry_w[g];
    end else begin : g_left
      assign left_w = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = entry_w[g];
    end else begin : g_right
      assign right_w = entry_w[g+1];
    end

    ilist_cell #(
      .CNT_W (CNT_W),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .pos_i   (position_i),
      .count_i (count_q),
      .value_i (item_value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[g]),
      .match_o (match_w[g])
    );
  end

  // Advance count and result registers; busy_q holds off requests until the first edge out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      count_q <= '0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
      srch_q  <= 1'b0;
    end else begin
      busy_q  <= 1'b0;
      count_q <= count_d;
      done_q  <= accept;
      ok_q    <= ok_d;
      srch_q  <= ctrl.srch;
    end
  end

  // Search result is the OR of the registered cell matches
  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign ok_o        = srch_q ? (|match_w) : ok_q;
  assign count_now_o = count_q;

endmodule

`default_nettype wire

// ----- sv/ilist_checker.sv -----
// ----------------------------------------------------------------------------
// ilist_checker
// Port-level checks of request/result timing and count behaviour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ilist_checker import ilist_pkg::*; #(
  parameter int unsigned CAPACITY = IlistCapacity,
  parameter int unsigned CNT_W    = 6
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                done_o,
  input wire logic [CNT_W-1:0]    count_now_o
);

  logic [CNT_W-1:0] count_prev_q;
  logic             count_step_ok;

  // Hold the count shown in the previous cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_prev_q <= '0;
    end else begin
      count_prev_q <= count_now_o;
    end
  end

  // Count is unchanged or one step away from the previous cycle
  assign count_step_ok = (count_now_o == count_prev_q) ||
                         (count_now_o == count_prev_q + 1'b1) ||
                         (count_now_o == count_prev_q - 1'b1);

  // Every request yields a result in the next cycle
  `ILIST_ASSERT(a_req_done, (start_i && !busy_o) |=> done_o)

  // No result without a request in the previous cycle
  `ILIST_ASSERT(a_done_req, done_o |-> $past(start_i && !busy_o))

  // Count stays within the store
  `ILIST_ASSERT_MSG(a_count_cap, count_now_o <= CNT_W'(CAPACITY), "count above capacity")

  // Back-to-back results move the count by at most one
  `ILIST_ASSERT_MSG(a_count_step, (done_o && $past(done_o)) |-> count_step_ok, "count jumped")

endmodule

bind indexed_list_insert_erase_search ilist_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_ilist_checker (.*);

`default_nettype wire

// ----- tb/sv/indexed_list_insert_erase_search_checker.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_search_checker
// Watches the request and result channels of the indexed list, keeps its own
// copy of the list, predicts each result and compares it with the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_insert_erase_search_checker import ilist_pkg::*; #(
  parameter int unsigned CAPACITY = IlistCapacity,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                busy_i,
  input  wire logic [CmdW-1:0]     cmd_i,
  input  wire logic [CNT_W-1:0]    position_i,
  input  wire logic signed [31:0]  item_value_i,
  input  wire logic                done_i,
  input  wire logic                ok_i,
  input  wire logic [CNT_W-1:0]    count_now_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output logic [CNT_W-1:0]         live_count_o,
  output int                       requests_o,
  output int                       search_hits_o,
  output int                       full_refusals_o
);

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count_now;
  } list_result_t;

  // Shadow copy of the list and the results still owed by the block
  logic signed [31:0] shadow_list [CAPACITY];
  logic [CNT_W-1:0]   live_count;
  list_result_t       owed_results [$];

  // Apply one request to the shadow list and return the result it gives
  function automatic list_result_t apply_request(logic [CmdW-1:0] cmd,
                                                 logic [CNT_W-1:0] pos,
                                                 logic signed [31:0] val);
    list_result_t res;
    res.ok = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (pos <= live_count && live_count < CAPACITY) begin
          for (int i = live_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          live_count = live_count + 1'b1;
          res.ok = 1'b1;
        end else if (live_count == CAPACITY) begin
          full_refusals_o++;
        end
      end
      CMD_ERASE: begin
        if (live_count != 0 && pos < live_count) begin
          for (int i = pos + 1; i < live_count; i++) shadow_list[i-1] = shadow_list[i];
          live_count = live_count - 1'b1;
          res.ok = 1'b1;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < live_count; i++) begin
          if (shadow_list[i] == val) res.ok = 1'b1;
        end
        if (res.ok) search_hits_o++;
      end
      default: res.ok = 1'b0;
    endcase
    res.count_now = live_count;
    return res;
  endfunction

  // Compare each result with the oldest owed one, then record a new request
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t oldest;
    if (!rst_ni) begin
      live_count = '0;
      owed_results.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      requests_o      = 0;
      search_hits_o   = 0;
      full_refusals_o = 0;
      live_count_o    = '0;
    end else begin
      if (done_i) begin
        if (owed_results.size() == 0) begin
          $error("result seen with no request outstanding");
          fail_count_o++;
        end else begin
          oldest = owed_results.pop_front();
          if (ok_i !== oldest.ok) begin
            $error("ok: expected %0b, actual %0b", oldest.ok, ok_i);
            fail_count_o++;
          end
          if (count_now_i !== oldest.count_now) begin
            $error("count_now: expected %0d, actual %0d", oldest.count_now, count_now_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        owed_results.push_back(apply_request(cmd_i, position_i, item_value_i));
        requests_o++;
      end
      pending_o    = owed_results.size();
      live_count_o = live_count;
    end
  end

endmodule

// ----- tb/sv/indexed_list_insert_erase_search_tb.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_search_tb
// Drives directed and random insert, erase and search requests into the list
// under several idling patterns; the checker beside the block judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_insert_erase_search_tb;
  import ilist_pkg::*;

  localparam int unsigned CNT_W       = $clog2(IlistCapacity + 1);
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 240;

  // Mix of operations in a random phase
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic [CmdW-1:0]         cmd_i = CMD_SEARCH;
  logic [CNT_W-1:0]        position_i = '0;
  logic signed [31:0]      item_value_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic                    ok_o;
  logic [CNT_W-1:0]        count_now_o;

  int                      fail_count;
  int                      pending;
  logic [CNT_W-1:0]        live_count;
  int                      requests;
  int                      search_hits;
  int                      full_refusals;
  int                      idle_pct = 0;
  int                      quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  indexed_list_insert_erase_search u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .count_now_o  (count_now_o)
  );

  indexed_list_insert_erase_search_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .cmd_i           (cmd_i),
    .position_i      (position_i),
    .item_value_i    (item_value_i),
    .done_i          (done_o),
    .ok_i            (ok_o),
    .count_now_i     (count_now_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .live_count_o    (live_count),
    .requests_o      (requests),
    .search_hits_o   (search_hits),
    .full_refusals_o (full_refusals)
  );

  // Issue one request at the falling edge and hold it until it is taken
  task automatic send_request(logic [CmdW-1:0] cmd, logic [CNT_W-1:0] pos,
                              logic signed [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    cmd_i        <= cmd;
    position_i   <= pos;
    item_value_i <= val;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Pick a value: small pool for search hits, the extremes, or anything
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $signed($urandom_range(15)) - 8;
    if (r < 55) return 32'sh8000_0000;
    if (r < 60) return 32'sh7fff_ffff;
    return $urandom;
  endfunction

  // Build one random request, mostly with legal positions
  task automatic send_random(op_mix_e mix);
    int               r;
    int               ins_pct;
    int               ers_pct;
    logic [CmdW-1:0]  cmd;
    logic [CNT_W-1:0] pos;
    ins_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 20 : 35;
    ers_pct = (mix == MIX_FILL) ? 20 : (mix == MIX_DRAIN) ? 60 : 35;
    r = $urandom_range(99);
    if (r < 4) cmd = CMD_UNUSED;
    else if (r < 4 + ins_pct * 96 / 100) cmd = CMD_INSERT;
    else if (r < 4 + (ins_pct + ers_pct) * 96 / 100) cmd = CMD_ERASE;
    else cmd = CMD_SEARCH;
    if ($urandom_range(99) < 15) pos = CNT_W'($urandom_range(63));
    else if (cmd == CMD_INSERT) pos = CNT_W'($urandom_range(live_count));
    else if (live_count == 0) pos = '0;
    else pos = CNT_W'($urandom_range(live_count - 1));
    send_request(cmd, pos, pick_value());
  endtask

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("timeout: no request or result for %0d cycles", QUIET_LIMIT);
        $display("indexed_list_insert_erase_search verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    op_mix_e phase_mix  [6];
    int      phase_idle [6];
    phase_mix  = '{MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_FILL, MIX_DRAIN, MIX_EVEN};
    phase_idle = '{0, 86, 26, 26, 0, 86};

    // Hold reset, then release at a falling edge
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty list, extremes, edges of the position range
    idle_pct = 0;
    send_request(CMD_SEARCH, 6'd0,  32'sd0);
    send_request(CMD_ERASE,  6'd0,  32'sd0);
    send_request(CMD_INSERT, 6'd1,  32'sd5);
    send_request(CMD_INSERT, 6'd0,  32'sh7fff_ffff);
    send_request(CMD_INSERT, 6'd1,  32'sh8000_0000);
    send_request(CMD_INSERT, 6'd0,  -32'sd1);
    send_request(CMD_INSERT, 6'd1,  32'sd0);
    send_request(CMD_SEARCH, 6'd63, 32'sh8000_0000);
    send_request(CMD_SEARCH, 6'd0,  32'sh7fff_ffff);
    send_request(CMD_SEARCH, 6'd0,  32'sd12345);
    send_request(CMD_INSERT, 6'd63, 32'sh5555_5555);
    send_request(CMD_ERASE,  6'd63, 32'sd0);
    send_request(CMD_ERASE,  6'd4,  32'sd0);
    send_request(CMD_ERASE,  6'd1,  32'sd0);
    send_request(CMD_ERASE,  6'd0,  32'sd0);
    send_request(CMD_UNUSED, 6'd63, 32'shaaaa_aaaa);
    send_request(CMD_SEARCH, 6'd0,  32'sd0);
    send_request(CMD_ERASE,  6'd1,  32'sd0);
    send_request(CMD_INSERT, 6'd1,  32'shaaaa_aaaa);
    send_request(CMD_SEARCH, 6'd0,  -32'sd1);

    // Random phases: vary the operation mix and the sender's idling
    for (int p = 0; p < 6; p++) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(phase_mix[p]);
    end

    // Drain: stop requests and wait for every owed result
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("ran %0d requests over six mix and idling phases", requests);
    $display("%0d searches found their value, %0d inserts refused on a full store",
             search_hits, full_refusals);
    if (fail_count == 0) begin
      $display("indexed_list_insert_erase_search verification clean");
    end else begin
      $display("indexed_list_insert_erase_search verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ilist_pkg.sv
sv/ilist_cell.sv
sv/indexed_list_insert_erase_search.sv
sv/ilist_checker.sv
tb/sv/indexed_list_insert_erase_search_checker.sv
tb/sv/indexed_list_insert_erase_search_tb.sv
